// File: rtl/swd_line_bit_engine_defines.svh
// ----------------------------------------------------------------------------
// SWD line bit engine assertion macros
// Shared concurrent check macros, clocked on i_clk and held off in reset.
// ----------------------------------------------------------------------------
`ifndef SWD_LINE_BIT_ENGINE_DEFINES_SVH
`define SWD_LINE_BIT_ENGINE_DEFINES_SVH

// Check a consequence in the same cycle as its antecedent
`define SWD_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("swd line bit engine: same-cycle check failed");

// Check a consequence in the cycle after its antecedent
`define SWD_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("swd line bit engine: next-cycle check failed");

`endif

// File: rtl/swd_pkg.sv
// ----------------------------------------------------------------------------
// SWD line bit engine package
// Widths, request codes and the records passed between front, queue and back.
// ----------------------------------------------------------------------------
package swd_pkg;

    // Widths of the channel fields
    localparam int DATA_W     = 32;
    localparam int CNT_W      = 7;
    localparam int REQ_W      = 3;

    // Word size of the shift data path; write and read counts saturate here
    localparam int WORD_BITS  = 32;
    localparam int WORD_LIMIT = (WORD_BITS < DATA_W) ? WORD_BITS : DATA_W;
    localparam int IDX_W      = $clog2(WORD_LIMIT);

    // Longest run of fixed-level clocks
    localparam int MAX_FIXED  = 64;

    // Command queue between front and back
    localparam int Q_DEPTH    = 2;
    localparam int QP_W       = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int QC_W       = $clog2(Q_DEPTH + 1);

    // Line request codes
    typedef enum logic [REQ_W-1:0] {
        REQ_WR_RISE  = 3'd0,
        REQ_WR_FALL  = 3'd1,
        REQ_FIXED    = 3'd2,
        REQ_READ     = 3'd3,
        REQ_TURN_IN  = 3'd4,
        REQ_TURN_OUT = 3'd5
    } t_req;

    // Classified command, as queued for the back end
    typedef struct packed {
        logic              preamble;   // half period driven high first
        logic              setup;      // data set up before falling edge
        logic              driven;     // host drives the line
        logic              from_data;  // level comes from the data word
        logic              level;      // level when not from data
        logic [CNT_W-1:0]  count;      // clock periods after the preamble
        logic [DATA_W-1:0] data;       // bits to send, bit 0 first
        logic [DATA_W-1:0] rd;         // assembled read word for last period
    } t_cmd;

    // One clock period result
    typedef struct packed {
        logic              swdio_level;
        logic              swdio_driven;
        logic              setup_before_fall;
        logic              half_period;
        logic [DATA_W-1:0] read_data;
        logic              last;
    } t_res;

    // Queue status seen by both sides
    typedef struct packed {
        logic empty;
        logic full;
    } t_q_stat;

    // Back end sequencer states
    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_PRE  = 3'b010,
        ST_BITS = 3'b100
    } t_bstate;

endpackage

// File: rtl/swd_if.sv
// ----------------------------------------------------------------------------
// SWD line bit engine channels
// Valid/ready channels for line requests and clock period results.
// ----------------------------------------------------------------------------
interface swd_req_if import swd_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [REQ_W-1:0]  req_type;
    logic [DATA_W-1:0] payload;
    logic [CNT_W-1:0]  bit_count;
    logic              level;
    logic [DATA_W-1:0] sampled_line;

    modport source (
        output valid, req_type, payload, bit_count, level, sampled_line,
        input  ready
    );
    modport sink (
        input  valid, req_type, payload, bit_count, level, sampled_line,
        output ready
    );
endinterface

interface swd_res_if import swd_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              swdio_level;
    logic              swdio_driven;
    logic              setup_before_fall;
    logic              half_period;
    logic [DATA_W-1:0] read_data;
    logic              last;

    modport source (
        output valid, swdio_level, swdio_driven, setup_before_fall, half_period,
               read_data, last,
        input  ready
    );
    modport sink (
        input  valid, swdio_level, swdio_driven, setup_before_fall, half_period,
               read_data, last,
        output ready
    );
endinterface

// File: rtl/swd_line_bit_engine.sv
// ----------------------------------------------------------------------------
// SWD line bit engine
// Turns SWD line commands into one result per SWCLK period.
// ----------------------------------------------------------------------------
// Each accepted command yields one result per clock period: its bit count
// (writes and reads saturate at 32, fixed clocks at 64), one for a
// turnaround, plus a half-period preamble before a rising-edge write on a
// released line. The back-end sequencer emits one result per cycle while
// the sink is ready and loads each command from its idle state, so it
// takes no new command before it is through with the last one. A
// two-entry command queue lets the front end accept the next commands
// while the back end is still playing out earlier ones; commands that
// produce no period are dropped by the front end and never queued.
`include "swd_line_bit_engine_defines.svh"

module swd_line_bit_engine import swd_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    swd_req_if.sink    i_req,
    swd_res_if.source  o_res
);

    logic    push;
    logic    pop;
    t_cmd    push_cmd;
    t_cmd    head_cmd;
    t_q_stat q_stat;

    // Accept and classify commands
    swd_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_req    (i_req),
        .i_q_stat (q_stat),
        .o_push   (push),
        .o_cmd    (push_cmd)
    );

    // Buffer classified commands
    swd_cmdq u_cmdq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .i_pop   (pop),
        .o_head  (head_cmd),
        .o_stat  (q_stat)
    );

    // Play commands out as clock periods
    swd_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_q_stat (q_stat),
        .i_head   (head_cmd),
        .o_pop    (pop),
        .o_res    (o_res)
    );

    // Queue never reads as both empty and full
    `SWD_ASSERT_NOW(a_q_stat_sane, 1'b1, !(q_stat.empty && q_stat.full))
    // Preamble is driven high with no setup and no read data
    `SWD_ASSERT_NOW(a_preamble_shape, o_res.valid && o_res.half_period,
        o_res.swdio_level && o_res.swdio_driven && !o_res.setup_before_fall
        && (o_res.read_data == '0))
    // Read data shows only on the final period of a command
    `SWD_ASSERT_NOW(a_read_on_last, o_res.valid && (o_res.read_data != '0), o_res.last)
    // An accepted turnaround always lands in the queue
    `SWD_ASSERT_NEXT(a_turn_queued,
        i_req.valid && i_req.ready && (i_req.req_type == REQ_TURN_IN), !q_stat.empty)

endmodule

// File: rtl/swd_front.sv
// ----------------------------------------------------------------------------
// SWD line bit engine front end
// Accepts line requests, tracks line state and queues classified commands.
// ----------------------------------------------------------------------------
module swd_front import swd_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    swd_req_if.sink    i_req,
    input  t_q_stat    i_q_stat,
    output logic       o_push,
    output t_cmd       o_cmd
);

    logic              r_released;
    logic              r_level;
    logic              n_released;
    logic              n_level;
    logic              accept;
    logic              keep;
    logic [CNT_W-1:0]  n_word;
    logic [CNT_W-1:0]  n_fixed;
    logic [CNT_W-1:0]  last_pos;
    logic [IDX_W-1:0]  last_idx;
    logic              last_bit;
    logic [DATA_W-1:0] mask;

    assign i_req.ready = !i_q_stat.full;
    assign accept      = i_req.valid && i_req.ready;
    assign o_push      = accept && keep;

    // Saturate counts and pick the final written bit
    always_comb begin
        n_word   = (i_req.bit_count > CNT_W'(WORD_LIMIT)) ? CNT_W'(WORD_LIMIT)
                                                          : i_req.bit_count;
        n_fixed  = (i_req.bit_count > CNT_W'(MAX_FIXED)) ? CNT_W'(MAX_FIXED)
                                                         : i_req.bit_count;
        last_pos = n_word - CNT_W'(1);
        last_idx = last_pos[IDX_W-1:0];
        last_bit = i_req.payload[last_idx];
        for (int i = 0; i < DATA_W; i++) begin
            mask[i] = (CNT_W'(i) < n_word);
        end
    end

    // Classify the request and work out the line state it leaves
    always_comb begin
        n_released = r_released;
        n_level    = r_level;
        keep       = 1'b0;
        o_cmd      = '0;
        o_cmd.driven = 1'b1;
        case (i_req.req_type)
            REQ_WR_RISE: begin
                o_cmd.preamble  = r_released;
                o_cmd.from_data = 1'b1;
                o_cmd.count     = n_word;
                o_cmd.data      = i_req.payload;
                keep            = (n_word != '0) || r_released;
                n_released      = 1'b0;
                if (n_word != '0) begin
                    n_level = last_bit;
                end else if (r_released) begin
                    n_level = 1'b1;
                end
            end
            REQ_WR_FALL: begin
                o_cmd.setup     = 1'b1;
                o_cmd.from_data = 1'b1;
                o_cmd.count     = n_word;
                o_cmd.data      = i_req.payload;
                keep            = (n_word != '0);
                n_released      = 1'b0;
                if (n_word != '0) begin
                    n_level = last_bit;
                end
            end
            REQ_FIXED: begin
                o_cmd.setup = 1'b1;
                o_cmd.level = i_req.level;
                o_cmd.count = n_fixed;
                keep        = (n_fixed != '0);
                n_released  = 1'b0;
                n_level     = i_req.level;
            end
            REQ_READ: begin
                o_cmd.driven = !r_released;
                o_cmd.level  = r_level;
                o_cmd.count  = n_word;
                o_cmd.rd     = i_req.sampled_line & mask;
                keep         = (n_word != '0);
            end
            REQ_TURN_IN: begin
                o_cmd.driven = 1'b0;
                o_cmd.level  = r_level;
                o_cmd.count  = CNT_W'(1);
                keep         = 1'b1;
                n_released   = 1'b1;
            end
            REQ_TURN_OUT: begin
                o_cmd.level = r_level;
                o_cmd.count = CNT_W'(1);
                keep        = 1'b1;
                n_released  = 1'b0;
            end
            default: begin
                // drop unknown requests without touching the line state
                keep = 1'b0;
            end
        endcase
    end

    // Advance line state on each accepted transaction
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_released <= 1'b0;
            r_level    <= 1'b0;
        end else if (accept) begin
            r_released <= n_released;
            r_level    <= n_level;
        end
    end

endmodule

// File: rtl/swd_cmdq.sv
// ----------------------------------------------------------------------------
// SWD line bit engine command queue
// Short register queue that decouples the front end from the back end.
// ----------------------------------------------------------------------------
module swd_cmdq import swd_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_push,
    input  t_cmd     i_cmd,
    input  logic     i_pop,
    output t_cmd     o_head,
    output t_q_stat  o_stat
);

    t_cmd             r_mem [Q_DEPTH];
    logic [QP_W-1:0]  r_wptr;
    logic [QP_W-1:0]  r_rptr;
    logic [QC_W-1:0]  r_count;
    logic             do_push;
    logic             do_pop;

    assign o_stat.empty = (r_count == '0);
    assign o_stat.full  = (r_count == QC_W'(Q_DEPTH));
    assign do_push      = i_push && !o_stat.full;
    assign do_pop       = i_pop && !o_stat.empty;
    assign o_head       = r_mem[r_rptr];

    function automatic logic [QP_W-1:0] wrap_inc(input logic [QP_W-1:0] ptr);
        return (ptr == QP_W'(Q_DEPTH - 1)) ? '0 : ptr + QP_W'(1);
    endfunction

    // Store entries
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_cmd;
        end
    end

    // Advance pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wptr <= wrap_inc(r_wptr);
            end
            if (do_pop) begin
                r_rptr <= wrap_inc(r_rptr);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + QC_W'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - QC_W'(1);
            end
        end
    end

endmodule

// File: rtl/swd_back.sv
// ----------------------------------------------------------------------------
// SWD line bit engine back end
// Plays one queued command as clock period results into an output register.
// ----------------------------------------------------------------------------
module swd_back import swd_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_q_stat    i_q_stat,
    input  t_cmd       i_head,
    output logic       o_pop,
    swd_res_if.source  o_res
);

    t_bstate           r_state;
    t_bstate           n_state;
    t_cmd              r_cur;
    logic [DATA_W-1:0] r_data;
    logic [CNT_W-1:0]  r_rem;
    logic              r_res_valid;
    t_res              r_res;
    logic              can_emit;
    logic              emit;
    t_res              n_res;

    assign can_emit = !r_res_valid || o_res.ready;
    assign o_pop    = (r_state == ST_IDLE) && !i_q_stat.empty;

    // Build the next period and pick the next state
    always_comb begin
        n_state = r_state;
        emit    = 1'b0;
        n_res   = '0;
        case (r_state)
            ST_IDLE: begin
                if (!i_q_stat.empty) begin
                    n_state = i_head.preamble ? ST_PRE : ST_BITS;
                end
            end
            ST_PRE: begin
                n_res.swdio_level  = 1'b1;
                n_res.swdio_driven = 1'b1;
                n_res.half_period  = 1'b1;
                n_res.last         = (r_rem == '0);
                if (can_emit) begin
                    emit    = 1'b1;
                    n_state = (r_rem == '0) ? ST_IDLE : ST_BITS;
                end
            end
            ST_BITS: begin
                n_res.swdio_level       = r_cur.from_data ? r_data[0] : r_cur.level;
                n_res.swdio_driven      = r_cur.driven;
                n_res.setup_before_fall = r_cur.setup;
                n_res.last              = (r_rem == CNT_W'(1));
                n_res.read_data         = (r_rem == CNT_W'(1)) ? r_cur.rd : '0;
                if (can_emit) begin
                    emit    = 1'b1;
                    n_state = (r_rem == CNT_W'(1)) ? ST_IDLE : ST_BITS;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Load a command, then shift data and count periods down
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_rem   <= '0;
        end else begin
            r_state <= n_state;
            if (o_pop) begin
                r_rem <= i_head.count;
            end else if (emit && (r_state == ST_BITS)) begin
                r_rem <= r_rem - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_cur  <= i_head;
            r_data <= i_head.data;
        end else if (emit && (r_state == ST_BITS)) begin
            r_data <= r_data >> 1;
        end
    end

    // Hold the result until the sink takes it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_valid <= 1'b0;
        end else if (emit) begin
            r_res_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_res_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_res <= n_res;
        end
    end

    assign o_res.valid             = r_res_valid;
    assign o_res.swdio_level       = r_res.swdio_level;
    assign o_res.swdio_driven      = r_res.swdio_driven;
    assign o_res.setup_before_fall = r_res.setup_before_fall;
    assign o_res.half_period       = r_res.half_period;
    assign o_res.read_data         = r_res.read_data;
    assign o_res.last              = r_res.last;

endmodule

// File: verif/swd_line_bit_engine_checker.sv
// ----------------------------------------------------------------------------
// SWD line bit engine checker
// Watches the request and result channels, predicts every clock period from
// the accepted line commands and compares each accepted result in order.
// ----------------------------------------------------------------------------
module swd_line_bit_engine_checker import swd_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    swd_req_if   i_req,
    swd_res_if   i_res,
    output int   o_err_cnt,
    output int   o_pending,
    output int   o_periods
);

    // Clock periods still owed by the block, oldest first
    t_res period_q[$];

    // Shadow of the line state: released to the pull-up, and last level
    logic line_rel;
    logic line_lvl;

    t_res got_res;
    t_res want_res;

    function automatic t_res mk_period(input logic lvl, drv, setup, half,
                                       input logic [DATA_W-1:0] rd,
                                       input logic lst);
        t_res p;
        p.swdio_level       = lvl;
        p.swdio_driven      = drv;
        p.setup_before_fall = setup;
        p.half_period       = half;
        p.read_data         = rd;
        p.last              = lst;
        return p;
    endfunction

    // Expand one line command into the clock periods it must produce
    task automatic plan_cmd(input logic [REQ_W-1:0] kind,
                            input logic [DATA_W-1:0] data,
                            input logic [CNT_W-1:0] cnt,
                            input logic lvl,
                            input logic [DATA_W-1:0] samp);
        int n_word;
        int n_fix;
        logic [DATA_W-1:0] acc;
        n_word = (int'(cnt) > WORD_LIMIT) ? WORD_LIMIT : int'(cnt);
        n_fix  = (int'(cnt) > MAX_FIXED) ? MAX_FIXED : int'(cnt);
        acc    = '0;
        case (kind)
            REQ_WR_RISE: begin
                // a released line gets a driven-high half period first
                if (line_rel) begin
                    line_rel = 1'b0;
                    line_lvl = 1'b1;
                    period_q.push_back(mk_period(1'b1, 1'b1, 1'b0, 1'b1, '0,
                                                 n_word == 0));
                end
                for (int i = 0; i < n_word; i++) begin
                    line_lvl = data[i];
                    period_q.push_back(mk_period(line_lvl, 1'b1, 1'b0, 1'b0, '0,
                                                 i + 1 == n_word));
                end
            end
            REQ_WR_FALL: begin
                line_rel = 1'b0;
                for (int i = 0; i < n_word; i++) begin
                    line_lvl = data[i];
                    period_q.push_back(mk_period(line_lvl, 1'b1, 1'b1, 1'b0, '0,
                                                 i + 1 == n_word));
                end
            end
            REQ_FIXED: begin
                line_lvl = lvl;
                line_rel = 1'b0;
                for (int i = 0; i < n_fix; i++)
                    period_q.push_back(mk_period(line_lvl, 1'b1, 1'b1, 1'b0, '0,
                                                 i + 1 == n_fix));
            end
            REQ_READ: begin
                // assemble the sampled bits, reported on the last period only
                for (int i = 0; i < n_word; i++) begin
                    acc[i] = samp[i];
                    period_q.push_back(mk_period(line_lvl, !line_rel, 1'b0, 1'b0,
                                                 (i + 1 == n_word) ? acc : '0,
                                                 i + 1 == n_word));
                end
            end
            REQ_TURN_IN: begin
                line_rel = 1'b1;
                period_q.push_back(mk_period(line_lvl, 1'b0, 1'b0, 1'b0, '0, 1'b1));
            end
            REQ_TURN_OUT: begin
                line_rel = 1'b0;
                period_q.push_back(mk_period(line_lvl, 1'b1, 1'b0, 1'b0, '0, 1'b1));
            end
            default: begin
                // unknown request: no period, no state change
            end
        endcase
    endtask

    task automatic flag_field(input string name, input logic [DATA_W-1:0] want,
                              input logic [DATA_W-1:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h",
                     $time, name, want, got);
            o_err_cnt++;
        end
    endtask

    // Predict on each request transaction, compare on each result transaction
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            period_q.delete();
            line_rel  = 1'b0;
            line_lvl  = 1'b0;
            o_err_cnt = 0;
            o_periods = 0;
        end else begin
            if (i_req.valid && i_req.ready)
                plan_cmd(i_req.req_type, i_req.payload, i_req.bit_count,
                         i_req.level, i_req.sampled_line);
            if (i_res.valid && i_res.ready) begin
                got_res = mk_period(i_res.swdio_level, i_res.swdio_driven,
                                    i_res.setup_before_fall, i_res.half_period,
                                    i_res.read_data, i_res.last);
                o_periods++;
                if (period_q.size() == 0) begin
                    $display("%0t: unexpected result, expected none, actual 0x%0h",
                             $time, got_res);
                    o_err_cnt++;
                end else begin
                    want_res = period_q.pop_front();
                    flag_field("swdio_level", want_res.swdio_level,
                               got_res.swdio_level);
                    flag_field("swdio_driven", want_res.swdio_driven,
                               got_res.swdio_driven);
                    flag_field("setup_before_fall", want_res.setup_before_fall,
                               got_res.setup_before_fall);
                    flag_field("half_period", want_res.half_period,
                               got_res.half_period);
                    flag_field("read_data", want_res.read_data, got_res.read_data);
                    flag_field("last", want_res.last, got_res.last);
                end
            end
        end
        o_pending <= period_q.size();
    end

endmodule

// File: verif/swd_line_bit_engine_tb.sv
// ----------------------------------------------------------------------------
// SWD line bit engine testbench
// Drives directed and random line commands with random idling on both
// channels; the checker predicts and compares every clock period.
// ----------------------------------------------------------------------------
module swd_line_bit_engine_tb;
    import swd_pkg::*;

    // Request codes the block must ignore
    localparam logic [REQ_W-1:0] REQ_UNUSED_6 = 3'd6;
    localparam logic [REQ_W-1:0] REQ_UNUSED_7 = 3'd7;

    localparam int RANDOM_ITEMS = 145;
    localparam int CALM_TAIL    = 30;
    localparam int DRAIN_CYCLES = 80;
    localparam int STALL_LIMIT  = 1000;

    logic clk = 1'b0;
    logic rst_n;

    swd_req_if req_ch ();
    swd_res_if res_ch ();

    int  err_cnt;
    int  pending;
    int  periods;
    int  cmd_cnt [8];
    int  work_cnt;
    int  stall_cycles;
    int  sink_hold;
    bit  src_idle_en;
    bit  sink_idle_en;
    bit  calm;

    swd_line_bit_engine uut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_req   (req_ch),
        .o_res   (res_ch)
    );

    swd_line_bit_engine_checker chk (
        .i_clk     (clk),
        .i_rst_n   (rst_n),
        .i_req     (req_ch),
        .i_res     (res_ch),
        .o_err_cnt (err_cnt),
        .o_pending (pending),
        .o_periods (periods)
    );

    always #2 clk = ~clk;

    // Stop the run when no transaction moves for too long
    always @(posedge clk) begin
        if (!rst_n || (req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
            $display("swd_line_bit_engine_tb: FAIL");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // Result side: accept, with random bursts of back-pressure
    initial begin
        sink_hold = 0;
        res_ch.ready <= 1'b0;
        forever begin
            @(posedge clk);
            if (sink_hold > 0) begin
                sink_hold--;
            end else if (sink_idle_en && $urandom_range(0, 7) == 0) begin
                sink_hold = $urandom_range(1, 13) - 1;
                res_ch.ready <= 1'b0;
            end else begin
                res_ch.ready <= 1'b1;
            end
        end
    end

    // Present one line command and hold it until the block takes it
    task automatic issue_cmd(input logic [REQ_W-1:0] kind,
                             input logic [DATA_W-1:0] data,
                             input logic [CNT_W-1:0] cnt,
                             input logic lvl,
                             input logic [DATA_W-1:0] samp);
        int gap;
        if (src_idle_en && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 13);
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_ch.valid        <= 1'b1;
        req_ch.req_type     <= kind;
        req_ch.payload      <= data;
        req_ch.bit_count    <= cnt;
        req_ch.level        <= lvl;
        req_ch.sampled_line <= samp;
        @(posedge clk);
        while (!req_ch.ready) @(posedge clk);
        cmd_cnt[kind]++;
        if (kind <= REQ_TURN_OUT)
            work_cnt++;
    endtask

    // Mostly short counts, some mid-size, a few past saturation
    function automatic logic [CNT_W-1:0] rand_count();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 70)
            return CNT_W'($urandom_range(0, 12));
        else if (pick < 90)
            return CNT_W'($urandom_range(13, 40));
        else
            return CNT_W'($urandom_range(41, 127));
    endfunction

    // One well-formed SWD access: header, turnaround, ack, then read data and turnaround or turnaround and write data
    task automatic issue_access();
        logic [DATA_W-1:0] ack;
        ack = ($urandom_range(0, 3) != 0) ? 32'h1 : $urandom;
        issue_cmd(REQ_WR_RISE, $urandom, 8, 1'($urandom), $urandom);
        issue_cmd(REQ_TURN_IN, $urandom, CNT_W'($urandom), 1'($urandom), $urandom);
        issue_cmd(REQ_READ, $urandom, 3, 1'($urandom), ack);
        if ($urandom_range(0, 1) == 0) begin
            issue_cmd(REQ_READ, $urandom, 32, 1'($urandom), $urandom);
            issue_cmd(REQ_READ, $urandom, 1, 1'($urandom), $urandom);
            issue_cmd(REQ_TURN_OUT, $urandom, CNT_W'($urandom), 1'($urandom), $urandom);
        end else begin
            issue_cmd(REQ_TURN_OUT, $urandom, CNT_W'($urandom), 1'($urandom), $urandom);
            issue_cmd(REQ_WR_RISE, $urandom, 32, 1'($urandom), $urandom);
            issue_cmd(REQ_WR_RISE, $urandom, 1, 1'($urandom), $urandom);
        end
        if ($urandom_range(0, 2) == 0)
            issue_cmd(REQ_FIXED, $urandom, CNT_W'($urandom_range(2, 8)), 1'b0, $urandom);
    endtask

    // Any single command, valid or not, with random content
    task automatic issue_noise();
        logic [REQ_W-1:0] kind;
        if ($urandom_range(0, 19) == 0)
            kind = REQ_W'($urandom_range(REQ_UNUSED_6, REQ_UNUSED_7));
        else
            kind = REQ_W'($urandom_range(REQ_WR_RISE, REQ_TURN_OUT));
        issue_cmd(kind, $urandom, rand_count(), 1'($urandom), $urandom);
    endtask

    initial begin
        work_cnt     = 0;
        stall_cycles = 0;
        calm         = 1'b0;
        src_idle_en  = 1'b1;
        sink_idle_en = 1'b1;
        foreach (cmd_cnt[k]) cmd_cnt[k] = 0;
        rst_n               <= 1'b0;
        req_ch.valid        <= 1'b0;
        req_ch.req_type     <= REQ_WR_RISE;
        req_ch.payload      <= '0;
        req_ch.bit_count    <= '0;
        req_ch.level        <= 1'b0;
        req_ch.sampled_line <= '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: field extremes, saturation, zero counts, preamble, ignores
        issue_cmd(REQ_WR_RISE, 32'hFFFF_FFFF, 32, 1'b0, '0);
        issue_cmd(REQ_WR_RISE, 32'h0, 127, 1'b1, 32'hFFFF_FFFF);
        issue_cmd(REQ_TURN_IN, $urandom, 1, 1'b0, $urandom);
        issue_cmd(REQ_WR_RISE, $urandom, 0, 1'b0, $urandom);
        issue_cmd(REQ_WR_RISE, $urandom, 0, 1'b1, $urandom);
        issue_cmd(REQ_TURN_IN, $urandom, 127, 1'b1, $urandom);
        issue_cmd(REQ_WR_RISE, 32'h15, 5, 1'b0, $urandom);
        issue_cmd(REQ_WR_FALL, 32'hA5A5_5A5A, 32, 1'b0, $urandom);
        issue_cmd(REQ_WR_FALL, 32'h8000_0001, 127, 1'b0, $urandom);
        issue_cmd(REQ_WR_FALL, $urandom, 0, 1'b0, $urandom);
        issue_cmd(REQ_FIXED, $urandom, 64, 1'b1, $urandom);
        issue_cmd(REQ_FIXED, $urandom, 127, 1'b0, $urandom);
        issue_cmd(REQ_FIXED, $urandom, 0, 1'b1, $urandom);
        issue_cmd(REQ_READ, $urandom, 32, 1'b0, 32'hFFFF_FFFF);
        issue_cmd(REQ_READ, $urandom, 1, 1'b1, 32'h0);
        issue_cmd(REQ_READ, $urandom, 127, 1'b0, $urandom);
        issue_cmd(REQ_TURN_IN, $urandom, 0, 1'b0, $urandom);
        issue_cmd(REQ_READ, $urandom, 8, 1'b0, $urandom);
        issue_cmd(REQ_TURN_IN, $urandom, 3, 1'b1, $urandom);
        issue_cmd(REQ_WR_FALL, $urandom, 4, 1'b0, $urandom);
        issue_cmd(REQ_TURN_OUT, $urandom, 0, 1'b1, $urandom);
        issue_cmd(REQ_READ, $urandom, 0, 1'b0, $urandom);
        issue_cmd(REQ_UNUSED_6, 32'hFFFF_FFFF, 127, 1'b1, 32'hFFFF_FFFF);
        issue_cmd(REQ_UNUSED_7, $urandom, CNT_W'($urandom), 1'b0, $urandom);
        issue_cmd(REQ_TURN_OUT, $urandom, 127, 1'b0, $urandom);

        // Random: mostly well-formed accesses, with line resets and noise
        work_cnt = 0;
        while (work_cnt < RANDOM_ITEMS) begin
            if (work_cnt >= RANDOM_ITEMS - CALM_TAIL) begin
                calm = 1'b1;
            end else if ($urandom_range(0, 9) == 0) begin
                calm = !calm;
            end
            src_idle_en  = !calm;
            sink_idle_en = !calm;
            case ($urandom_range(0, 19))
                0: begin
                    issue_cmd(REQ_FIXED, $urandom, CNT_W'($urandom_range(50, 64)), 1'b1,
                              $urandom);
                    issue_cmd(REQ_FIXED, $urandom, 2, 1'b0, $urandom);
                end
                1, 2, 3, 4, 5, 6, 7, 8, 9, 10, 11: issue_access();
                default: issue_noise();
            endcase
        end

        // Drain: wait for every owed period, then a quiet spell
        req_ch.valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("covered %0d wr_rise, %0d wr_fall, %0d fixed, %0d read, %0d turn_in,",
                 cmd_cnt[REQ_WR_RISE], cmd_cnt[REQ_WR_FALL], cmd_cnt[REQ_FIXED],
                 cmd_cnt[REQ_READ], cmd_cnt[REQ_TURN_IN]);
        $display("%0d turn_out and %0d unknown commands; %0d clock periods checked",
                 cmd_cnt[REQ_TURN_OUT], cmd_cnt[REQ_UNUSED_6] + cmd_cnt[REQ_UNUSED_7],
                 periods);
        if (err_cnt == 0 && pending == 0) begin
            $display("swd_line_bit_engine_tb: PASS");
        end else begin
            $display("swd_line_bit_engine_tb: FAIL");
        end
        $finish;
    end

endmodule
